[hdl/lvl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Levels adjust package
// Shared widths, latencies, register codes and elaboration-time constant
// functions for the levels adjust pixel pipeline.
// ----------------------------------------------------------------------------
package lvl_pkg;

  localparam int unsigned PIX_W    = 16;
  localparam int unsigned GAM_W    = 11;
  localparam int unsigned LOG_FRAC = 24;
  localparam int unsigned LOG_W    = LOG_FRAC + 4;
  localparam int unsigned QUO_W    = 32;
  localparam int unsigned EXP_W    = QUO_W - LOG_FRAC;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;

  localparam logic [GAM_W-1:0] GAMMA_MIN = 11'd26;
  localparam logic [GAM_W-1:0] GAMMA_MAX = 11'd1280;
  localparam logic [GAM_W-1:0] GAMMA_ONE = 11'd256;

  // Stage counts of each unit
  localparam int unsigned IN_LAT   = PIX_W + 1;
  localparam int unsigned LOG_LAT  = LOG_FRAC + 1;
  localparam int unsigned POW_LAT  = 1 + QUO_W + LOG_FRAC + 2;
  localparam int unsigned OUT_LAT  = 3;
  localparam int unsigned PIPE_LAT = IN_LAT + LOG_LAT + POW_LAT + OUT_LAT;

  typedef enum logic [2:0] {
    REG_IN_BLACK  = 3'd0,
    REG_IN_WHITE  = 3'd1,
    REG_GAMMA     = 3'd2,
    REG_OUT_BLACK = 3'd3,
    REG_OUT_WHITE = 3'd4
  } lvl_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] in_black;
    logic [PIX_W-1:0] in_white;
    logic [GAM_W-1:0] gamma;
    logic [PIX_W-1:0] out_black;
    logic [PIX_W-1:0] out_white;
  } lvl_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] alpha;
  } lvl_pix_t;

  function automatic logic [GAM_W-1:0] gamma_sat(input logic [GAM_W-1:0] g);
    if (g < GAMMA_MIN) begin
      return GAMMA_MIN;
    end else if (g > GAMMA_MAX) begin
      return GAMMA_MAX;
    end
    return g;
  endfunction

  // Integer square root, used only to build constants
  function automatic logic [31:0] isqrt64(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = n;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  // 2^(-2^-i) in Q32, by repeated square roots of one half
  function automatic logic [31:0] exp_root(input int unsigned i);
    logic [63:0] r;
    r = 64'h0000_0000_8000_0000;
    for (int unsigned j = 1; j <= i; j++) begin
      r = {32'd0, isqrt64(r << 32)};
    end
    return r[31:0];
  endfunction

  // log2 in Q.24 by normalise and square, matching the hardware unit
  function automatic logic [LOG_W-1:0] log2_const(input logic [PIX_W-1:0] t);
    logic [3:0]          e;
    logic [63:0]         m;
    logic [LOG_FRAC-1:0] frac;
    e    = '0;
    frac = '0;
    for (int b = 0; b < PIX_W; b++) begin
      if (t[b]) e = 4'(b);
    end
    m = 64'(t) << (31 - e);
    for (int i = 1; i <= LOG_FRAC; i++) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m    = m >> 1;
        frac = {frac[LOG_FRAC-2:0], 1'b1};
      end else begin
        frac = {frac[LOG_FRAC-2:0], 1'b0};
      end
    end
    return {e, frac};
  endfunction

  localparam logic [LOG_W-1:0] LOG2_FULL = log2_const(16'hFFFF);

endpackage

[hdl/lvl_pix_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Levels adjust pixel channels
// Valid/ready channels for input pixels and adjusted output pixels.
// ----------------------------------------------------------------------------
interface lvl_pix_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_in;
  logic [15:0] green_in;
  logic [15:0] blue_in;
  logic [15:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input alpha_in, output ready);
endinterface

interface lvl_pix_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;
  logic [15:0] alpha_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input alpha_out, output ready);
endinterface

[hdl/lvl_in_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input level remap
// Maps in_black..in_white onto 0..1 with a bit-per-stage rounded divider.
// ----------------------------------------------------------------------------
module lvl_in_map (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  lvl_pkg::lvl_cfg_t        cfg_i,
  input  logic [lvl_pkg::PIX_W-1:0] value_i,
  output logic [lvl_pkg::PIX_W-1:0] value_o
);

  localparam int unsigned W     = lvl_pkg::PIX_W;
  localparam int unsigned STEPS = lvl_pkg::IN_LAT - 1;

  logic         active;
  logic [W-1:0] d;
  logic [W-1:0] n;
  logic [2*W-1:0] num;
  logic         byp;
  logic [W-1:0] bv;

  logic [2*W-1:0] acc_q [STEPS+1];
  logic           byp_q [STEPS+1];
  logic [W-1:0]   bv_q  [STEPS+1];

  always_comb begin
    active = cfg_i.in_white > cfg_i.in_black;
    d      = cfg_i.in_white - cfg_i.in_black;
    n      = value_i - cfg_i.in_black;
    num    = ({n, {W{1'b0}}} - {{W{1'b0}}, n}) + {{(W+1){1'b0}}, d[W-1:1]};
    // Settle the saturated and pass-through cases here
    byp    = 1'b1;
    bv     = value_i;
    if (active) begin
      if (value_i <= cfg_i.in_black) begin
        bv = '0;
      end else if (n >= d) begin
        bv = '1;
      end else begin
        byp = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q[0] <= num;
      byp_q[0] <= byp;
      bv_q[0]  <= bv;
    end
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;
    assign trial = acc_q[s][2*W-1:W-1];
    assign ge    = trial >= {1'b0, d};
    assign diff  = trial - {1'b0, d};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[s+1] <= {(ge ? diff[W-1:0] : trial[W-1:0]), acc_q[s][W-2:0], ge};
        byp_q[s+1] <= byp_q[s];
        bv_q[s+1]  <= bv_q[s];
      end
    end
  end

  assign value_o = byp_q[STEPS] ? bv_q[STEPS] : acc_q[STEPS][W-1:0];

endmodule

[hdl/lvl_log2.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Log2 unit
// Normalise, then one squaring stage per fraction bit; gives the distance
// of the value below full scale in Q.24.
// ----------------------------------------------------------------------------
module lvl_log2 (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [lvl_pkg::PIX_W-1:0] value_i,
  output logic [lvl_pkg::PIX_W-1:0] value_o,
  output logic [lvl_pkg::LOG_W-1:0] log_o
);

  localparam int unsigned W  = lvl_pkg::PIX_W;
  localparam int unsigned FR = lvl_pkg::LOG_FRAC;

  logic [3:0] e;

  logic [31:0]   m_q    [FR+1];
  logic [3:0]    e_q    [FR+1];
  logic [FR-1:0] frac_q [FR+1];
  logic [W-1:0]  t_q    [FR+1];

  always_comb begin
    e = '0;
    for (int b = 0; b < W; b++) begin
      if (value_i[b]) e = 4'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]    <= 32'(value_i) << (5'd31 - {1'b0, e});
      e_q[0]    <= e;
      frac_q[0] <= '0;
      t_q[0]    <= value_i;
    end
  end

  for (genvar s = 0; s < FR; s++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] sh;
    assign sq = m_q[s] * m_q[s];
    assign sh = sq[63:31];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[s+1]    <= sh[32] ? sh[32:1] : sh[31:0];
        frac_q[s+1] <= {frac_q[s][FR-2:0], sh[32]};
        e_q[s+1]    <= e_q[s];
        t_q[s+1]    <= t_q[s];
      end
    end
  end

  assign log_o   = lvl_pkg::LOG2_FULL - {e_q[FR], frac_q[FR]};
  assign value_o = t_q[FR];

endmodule

[hdl/lvl_pow.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamma power unit
// Divides the log by gamma one quotient bit per stage, rebuilds 2^-x from
// a table of roots one bit per stage, then scales and rounds to 16 bits.
// ----------------------------------------------------------------------------
module lvl_pow (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [lvl_pkg::GAM_W-1:0] gamma_i,
  input  logic [lvl_pkg::PIX_W-1:0] value_i,
  input  logic [lvl_pkg::LOG_W-1:0] log_i,
  output logic [lvl_pkg::PIX_W-1:0] value_o
);

  localparam int unsigned W   = lvl_pkg::PIX_W;
  localparam int unsigned GW  = lvl_pkg::GAM_W;
  localparam int unsigned QW  = lvl_pkg::QUO_W;
  localparam int unsigned FR  = lvl_pkg::LOG_FRAC;
  localparam int unsigned KW  = lvl_pkg::EXP_W;
  localparam int unsigned NW  = lvl_pkg::LOG_W + 9;
  localparam int unsigned AW  = GW + QW;
  localparam int unsigned SCW = 33 + W;

  logic [GW-1:0] g;
  logic          skip;
  logic [NW-1:0] num;

  // Divider stages
  logic [AW-1:0] dacc_q [QW+1];
  logic          dskip_q [QW+1];
  logic [W-1:0]  dt_q   [QW+1];

  // Power stages
  logic [32:0]   p_q    [FR];
  logic [FR-1:0] f_q    [FR];
  logic [KW-1:0] k_q    [FR];
  logic          pskip_q [FR];
  logic [W-1:0]  pt_q   [FR];

  // Scale and round
  logic [SCW-1:0] sc_q;
  logic [KW-1:0]  sck_q;
  logic           scskip_q;
  logic [W-1:0]   sct_q;
  logic [W-1:0]   res_q;
  logic           rskip_q;
  logic [W-1:0]   rt_q;

  always_comb begin
    g    = lvl_pkg::gamma_sat(gamma_i);
    skip = (g == lvl_pkg::GAMMA_ONE) || (value_i == '0);
    num  = {1'b0, log_i, 8'd0} + NW'(g >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dacc_q[0]  <= AW'(num);
      dskip_q[0] <= skip;
      dt_q[0]    <= value_i;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    logic [GW:0] trial;
    logic [GW:0] diff;
    logic        ge;
    assign trial = dacc_q[s][AW-1:QW-1];
    assign ge    = trial >= {1'b0, g};
    assign diff  = trial - {1'b0, g};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dacc_q[s+1]  <= {(ge ? diff[GW-1:0] : trial[GW-1:0]), dacc_q[s][QW-2:0], ge};
        dskip_q[s+1] <= dskip_q[s];
        dt_q[s+1]    <= dt_q[s];
      end
    end
  end

  for (genvar j = 0; j < FR; j++) begin : g_exp
    localparam logic [31:0] ROOT = lvl_pkg::exp_root(j + 1);
    logic [32:0]   p_src;
    logic [FR-1:0] f_src;
    logic [KW-1:0] k_src;
    logic          skip_src;
    logic [W-1:0]  t_src;
    logic [64:0]   prod;
    if (j == 0) begin : g_head
      assign p_src    = 33'h1_0000_0000;
      assign f_src    = dacc_q[QW][FR-1:0];
      assign k_src    = dacc_q[QW][QW-1:FR];
      assign skip_src = dskip_q[QW];
      assign t_src    = dt_q[QW];
    end else begin : g_body
      assign p_src    = p_q[j-1];
      assign f_src    = f_q[j-1];
      assign k_src    = k_q[j-1];
      assign skip_src = pskip_q[j-1];
      assign t_src    = pt_q[j-1];
    end
    assign prod = p_src * ROOT;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[j]     <= f_src[FR-1-j] ? prod[64:32] : p_src;
        f_q[j]     <= f_src;
        k_q[j]     <= k_src;
        pskip_q[j] <= skip_src;
        pt_q[j]    <= t_src;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sc_q     <= p_q[FR-1] * 16'hFFFF;
      sck_q    <= k_q[FR-1];
      scskip_q <= pskip_q[FR-1];
      sct_q    <= pt_q[FR-1];
    end
  end

  logic [5:0]  s_amt;
  logic [63:0] rsum;
  logic [63:0] rsh;
  logic [W-1:0] rval;

  always_comb begin
    s_amt = 6'd32 + sck_q[4:0];
    rsum  = 64'(sc_q) + (64'd1 << (s_amt - 6'd1));
    rsh   = rsum >> s_amt;
    if (sck_q >= KW'(31)) begin
      rval = '0;
    end else if (|rsh[63:W]) begin
      rval = '1;
    end else begin
      rval = rsh[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q   <= rval;
      rskip_q <= scskip_q;
      rt_q    <= sct_q;
    end
  end

  assign value_o = rskip_q ? rt_q : res_q;

endmodule

[hdl/lvl_out_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output level map
// Scales 0..1 into out_black..out_white, rounding the divide by full scale.
// ----------------------------------------------------------------------------
module lvl_out_map (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  lvl_pkg::lvl_cfg_t         cfg_i,
  input  logic [lvl_pkg::PIX_W-1:0] value_i,
  output logic [lvl_pkg::PIX_W-1:0] value_o
);

  localparam int unsigned W = lvl_pkg::PIX_W;
  localparam logic [17:0] FULL  = 18'd65535;
  localparam logic [17:0] FULL2 = 18'd131070;

  logic         inv;
  logic [W-1:0] d;

  logic [2*W-1:0] prod_q;
  logic [W:0]     qe_q;
  logic [17:0]    rem_q;
  logic [W-1:0]   value_q;

  logic [32:0] x;
  logic [33:0] xs;
  logic [W:0]  qe;
  logic [33:0] rem;
  logic [W:0]  q;

  always_comb begin
    inv = cfg_i.out_white < cfg_i.out_black;
    d   = inv ? cfg_i.out_black - cfg_i.out_white : cfg_i.out_white - cfg_i.out_black;
    x   = {1'b0, prod_q} + 33'd32767;
    xs  = {1'b0, x} + {17'd0, x[32:16]};
    qe  = xs[32:16];
    rem = {1'b0, x} + {17'd0, qe} - {1'b0, qe, 16'd0};
    if (rem_q >= FULL2) begin
      q = qe_q + 17'd2;
    end else if (rem_q >= FULL) begin
      q = qe_q + 17'd1;
    end else begin
      q = qe_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= value_i * d;
      qe_q    <= qe;
      rem_q   <= rem[17:0];
      value_q <= inv ? cfg_i.out_black - q[W-1:0] : cfg_i.out_black + q[W-1:0];
    end
  end

  assign value_o = value_q;

endmodule

[hdl/levels_adjust_pixel_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Levels adjust pixel core
// Per-pixel levels adjustment with gamma on RGB; alpha rides alongside.
// ----------------------------------------------------------------------------
//
//   channel   dir   kind        payload
//   pix_i     in    valid/ready red_in, green_in, blue_in, alpha_in (16 b each)
//   pix_o     out   valid/ready red_out, green_out, blue_out, alpha_out
//   apb       in    APB r/w     5 registers at byte offsets 0,4,8,12,16
//
// One beat enters per clock while the pipe is not stalled; the depth is
// set mainly by the 16-stage input divider, the 24 squaring stages of
// the log, the 32-stage gamma divider and the 24 root-multiply stages.
// The whole pipe advances together whenever the output register is empty
// or taken; a one-beat skid register on the input holds the beat offered
// while the pipe is stalled. rst_ni asynchronously clears all valid bits
// and the skid flag and loads the config defaults; pipe data is not reset.
// ----------------------------------------------------------------------------
module levels_adjust_pixel_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lvl_pix_in_if.sink                  pix_i,
  lvl_pix_out_if.source               pix_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lvl_pkg::ADDR_W-1:0]  paddr,
  input  logic [lvl_pkg::DATA_W-1:0]  pwdata,
  output logic [lvl_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned W   = lvl_pkg::PIX_W;
  localparam int unsigned LAT = lvl_pkg::PIPE_LAT;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  lvl_pkg::lvl_cfg_t cfg_q;
  lvl_pkg::lvl_reg_e reg_sel;
  logic              cfg_wr;

  assign reg_sel = lvl_pkg::lvl_reg_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.in_black  <= '0;
      cfg_q.in_white  <= '1;
      cfg_q.gamma     <= lvl_pkg::GAMMA_ONE;
      cfg_q.out_black <= '0;
      cfg_q.out_white <= '1;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        lvl_pkg::REG_IN_BLACK:  cfg_q.in_black  <= pwdata[W-1:0];
        lvl_pkg::REG_IN_WHITE:  cfg_q.in_white  <= pwdata[W-1:0];
        lvl_pkg::REG_GAMMA:     cfg_q.gamma     <= pwdata[lvl_pkg::GAM_W-1:0];
        lvl_pkg::REG_OUT_BLACK: cfg_q.out_black <= pwdata[W-1:0];
        lvl_pkg::REG_OUT_WHITE: cfg_q.out_white <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lvl_pkg::REG_IN_BLACK:  prdata = 32'(cfg_q.in_black);
      lvl_pkg::REG_IN_WHITE:  prdata = 32'(cfg_q.in_white);
      lvl_pkg::REG_GAMMA:     prdata = 32'(cfg_q.gamma);
      lvl_pkg::REG_OUT_BLACK: prdata = 32'(cfg_q.out_black);
      lvl_pkg::REG_OUT_WHITE: prdata = 32'(cfg_q.out_white);
      default:                prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input skid and pipe advance
  // --------------------------------------------------------------------------
  logic              en;
  logic              skid_v_q;
  lvl_pkg::lvl_pix_t skid_q;
  lvl_pkg::lvl_pix_t in_pix;
  lvl_pkg::lvl_pix_t front;
  logic              front_v;
  logic [LAT-1:0]    vld_q;
  logic [W-1:0]      alpha_q [LAT];

  // Advance whenever the output register is free or being drained
  assign en      = !vld_q[LAT-1] || pix_o.ready;
  assign pix_i.ready = !skid_v_q;

  assign in_pix  = '{red: pix_i.red_in, green: pix_i.green_in,
                     blue: pix_i.blue_in, alpha: pix_i.alpha_in};
  assign front   = skid_v_q ? skid_q : in_pix;
  assign front_v = skid_v_q || pix_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (en) begin
      skid_v_q <= 1'b0;
    end else if (pix_i.valid && !skid_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  // Hold the offered beat while the pipe is stalled
  always_ff @(posedge clk_i) begin
    if (!en && !skid_v_q) begin
      skid_q <= in_pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], front_v};
    end
  end

  // Alpha travels untouched beside the colour pipe
  always_ff @(posedge clk_i) begin
    if (en) begin
      alpha_q[0] <= front.alpha;
      for (int i = 1; i < LAT; i++) begin
        alpha_q[i] <= alpha_q[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Colour lanes: remap, log, power, output map
  // --------------------------------------------------------------------------
  logic [W-1:0] lane_in  [3];
  logic [W-1:0] lane_out [3];

  assign lane_in[0] = front.red;
  assign lane_in[1] = front.green;
  assign lane_in[2] = front.blue;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic [W-1:0]              rm_val;
    logic [W-1:0]              lg_val;
    logic [lvl_pkg::LOG_W-1:0] lg_log;
    logic [W-1:0]              pw_val;

    lvl_in_map u_in_map (
      .clk_i   (clk_i),
      .en_i    (en),
      .cfg_i   (cfg_q),
      .value_i (lane_in[c]),
      .value_o (rm_val)
    );

    lvl_log2 u_log2 (
      .clk_i   (clk_i),
      .en_i    (en),
      .value_i (rm_val),
      .value_o (lg_val),
      .log_o   (lg_log)
    );

    lvl_pow u_pow (
      .clk_i   (clk_i),
      .en_i    (en),
      .gamma_i (cfg_q.gamma),
      .value_i (lg_val),
      .log_i   (lg_log),
      .value_o (pw_val)
    );

    lvl_out_map u_out_map (
      .clk_i   (clk_i),
      .en_i    (en),
      .cfg_i   (cfg_q),
      .value_i (pw_val),
      .value_o (lane_out[c])
    );
  end

  assign pix_o.valid     = vld_q[LAT-1];
  assign pix_o.red_out   = lane_out[0];
  assign pix_o.green_out = lane_out[1];
  assign pix_o.blue_out  = lane_out[2];
  assign pix_o.alpha_out = alpha_q[LAT-1];

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_stall_holds_valids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipe valid bits moved during a stall");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !en) |=> skid_v_q)
    else $error("skid beat dropped while stalled");

  a_skid_means_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> vld_q[LAT-1])
    else $error("skid full without a waiting result");

endmodule
